@@ rtl/core/rpn_stack_calculator_top_assert.svh @@
// assertion macros used by the rpn_chk checker of the rpn stack calculator
`ifndef RPN_STACK_CALCULATOR_TOP_ASSERT_SVH
`define RPN_STACK_CALCULATOR_TOP_ASSERT_SVH

// property checked at every clock edge outside reset
`define RPN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication checked outside reset
`define RPN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rpn_pkg.sv @@
`default_nettype none

package rpn_pkg;

    localparam int WORD_W      = 32;
    localparam int IDX_W       = 10;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 11;
    localparam int STEP_W      = $clog2(WORD_W);

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = STATUS_W;
    localparam int S_PAD_W   = S_TDATA_W - WORD_W - IDX_W;
    localparam int M_PAD_W   = M_TDATA_W - WORD_W - DEPTH_OUT_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_PEEK_TOP    = 3'd2,
        OP_PEEK_BOTTOM = 3'd3,
        OP_ADD         = 3'd4,
        OP_SUB         = 3'd5,
        OP_MUL         = 3'd6,
        OP_DIV         = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_EMPTY        = 3'd2,
        ST_BAD_INDEX    = 3'd3,
        ST_FEW_OPERANDS = 3'd4,
        ST_DIV_ZERO     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_RD_LEFT,
        S_ALU_GO,
        S_ALU_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL,
        AS_ABS_A,
        AS_ABS_B,
        AS_DIV,
        AS_FIX,
        AS_DONE
    } alu_state_t;

    typedef struct packed {
        logic    start;
        opcode_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/rpn_ram.sv @@
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rpn_alu.sv @@
`default_nettype none

module rpn_alu
    import rpn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire alu_req_t          req,
    input  wire logic [WORD_W-1:0] left,
    input  wire logic [WORD_W-1:0] right,
    output alu_rsp_t               rsp,
    output logic      [WORD_W-1:0] result
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

    alu_state_t        state_reg, state_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] mcand_reg, mcand_next;     // multiplicand, or dividend/quotient
    logic [WORD_W-1:0] mplier_reg, mplier_next;   // multiplier, or divisor
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              sign_a_reg, sign_a_next;
    logic              sign_b_reg, sign_b_next;
    logic              divz_reg, divz_next;

    // the one shared adder
    logic [WORD_W:0]   add_a, add_b;
    logic              add_sub;
    logic [WORD_W+1:0] add_sum;
    logic              add_cout;

    assign add_sum  = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                    + (WORD_W+2)'(add_sub);
    assign add_cout = add_sum[WORD_W+1];

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            AS_IDLE:
            begin
                add_a   = {1'b0, left};
                add_b   = {1'b0, right};
                add_sub = (req.op == OP_SUB);
            end
            AS_MUL:
            begin
                add_a = {1'b0, acc_reg};
                add_b = {1'b0, mcand_reg};
            end
            AS_ABS_A, AS_FIX:
            begin
                add_b   = {1'b0, mcand_reg};
                add_sub = 1'b1;
            end
            AS_ABS_B:
            begin
                add_b   = {1'b0, mplier_reg};
                add_sub = 1'b1;
            end
            AS_DIV:
            begin
                add_a   = {rem_reg, mcand_reg[WORD_W-1]};
                add_b   = {1'b0, mplier_reg};
                add_sub = 1'b1;
            end
            AS_DONE:
            begin
                add_sub = 1'b0;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        sign_a_next = sign_a_reg;
        sign_b_next = sign_b_reg;
        divz_next   = divz_reg;
        rsp.done     = 1'b0;
        rsp.div_zero = divz_reg;

        unique case (state_reg)
            AS_IDLE:
            begin
                if (req.start)
                begin
                    divz_next = 1'b0;
                    cnt_next  = '0;
                    priority case (req.op)
                        OP_MUL:
                        begin
                            acc_next    = '0;
                            mcand_next  = left;
                            mplier_next = right;
                            state_next  = AS_MUL;
                        end
                        OP_DIV:
                        begin
                            mcand_next  = left;
                            mplier_next = right;
                            rem_next    = '0;
                            sign_a_next = left[WORD_W-1];
                            sign_b_next = right[WORD_W-1];
                            if (right == '0)
                            begin
                                divz_next  = 1'b1;
                                acc_next   = '0;
                                state_next = AS_DONE;
                            end
                            else
                            begin
                                state_next = AS_ABS_A;
                            end
                        end
                        default:
                        begin
                            // add and subtract finish in one pass
                            acc_next   = add_sum[WORD_W-1:0];
                            state_next = AS_DONE;
                        end
                    endcase
                end
            end
            AS_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = add_sum[WORD_W-1:0];
                end
                mcand_next  = {mcand_reg[WORD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[WORD_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = AS_DONE;
                end
            end
            AS_ABS_A:
            begin
                if (sign_a_reg)
                begin
                    mcand_next = add_sum[WORD_W-1:0];
                end
                state_next = AS_ABS_B;
            end
            AS_ABS_B:
            begin
                if (sign_b_reg)
                begin
                    mplier_next = add_sum[WORD_W-1:0];
                end
                state_next = AS_DIV;
            end
            AS_DIV:
            begin
                // restoring step: one quotient bit per cycle
                if (add_cout)
                begin
                    rem_next = add_sum[WORD_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[WORD_W-2:0], mcand_reg[WORD_W-1]};
                end
                mcand_next = {mcand_reg[WORD_W-2:0], add_cout};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = AS_FIX;
                end
            end
            AS_FIX:
            begin
                // floor toward minus infinity when signs differ
                if (sign_a_reg ^ sign_b_reg)
                begin
                    acc_next = (rem_reg != '0) ? ~mcand_reg : add_sum[WORD_W-1:0];
                end
                else
                begin
                    acc_next = mcand_reg;
                end
                state_next = AS_DONE;
            end
            AS_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = AS_IDLE;
            end
            default:
            begin
                state_next = AS_IDLE;
            end
        endcase
    end

    assign result = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        sign_a_reg <= sign_a_next;
        sign_b_reg <= sign_b_next;
        divz_reg   <= divz_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/rpn_stack_calculator_top.sv @@
// rpn stack calculator: a bounded operand stack for postfix integer arithmetic
//
// input channel s_*: one item per operation; s_tuser carries the opcode
// (push, pop, peek top, peek bottom, add, sub, mul, div), s_tdata carries
// the push value and the peek index. output channel m_*: exactly one item
// per input item with the result, the status code and the stack depth after
// the operation.
// one item is worked on at a time; s_tready is high only while the
// sequencer is idle. push and the failed checks finish without a stack
// memory read, pop and peeks do one stack memory read, and add, subtract,
// multiply and divide read both operands and then wait for the arithmetic
// unit; the shared adder in the arithmetic unit does one multiply or
// divide bit per cycle.
// the result sits in an output register: a new item is taken while the last
// result waits, but a finished item waits in the sequencer until m_tready
// frees that register, so a stalled receiver stops the block after one item.
// reset empties the stack and drops any pending result; the stack memory
// itself is not cleared, entries above the fill count are never read.
`default_nettype none

module rpn_stack_calculator_top
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // value[31:0], index[41:32], zero pad
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // operation[2:0]
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // result[31:0], depth_now[42:32], zero pad
    output logic      [M_TUSER_W-1:0] m_tuser    // status[2:0]
);

    localparam int AW   = $clog2(STACK_DEPTH);     // stack address width
    localparam int CW   = $clog2(STACK_DEPTH + 1); // fill count width
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    // sequencer state and item fields
    state_t             state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    opcode_t            op_reg, op_next;
    logic [WORD_W-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [WORD_W-1:0]  right_reg, right_next;
    logic [WORD_W-1:0]  res_reg, res_next;
    status_t            st_reg, st_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [M_TUSER_W-1:0] out_user_reg, out_user_next;

    // stack memory port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // arithmetic unit
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [WORD_W-1:0] alu_result;

    // stack addresses
    logic [CW-1:0]     top_pos, second_pos, peek_pos;
    logic [CMPW-1:0]   idx_ext, fill_ext;
    logic [CW+DEPTH_OUT_W-1:0] depth_wide;

    assign top_pos    = fill_reg - CW'(1);
    assign second_pos = fill_reg - CW'(2);
    assign peek_pos   = fill_reg - CW'(1) - CW'(idx_reg);
    assign idx_ext    = CMPW'(idx_reg);
    assign fill_ext   = CMPW'(fill_reg);
    // depth reported modulo 2^11
    assign depth_wide = {{DEPTH_OUT_W{1'b0}}, fill_reg};

    rpn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // left operand comes straight off the memory read port
    rpn_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .left   (ram_rdata),
        .right  (right_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        op_next    = op_reg;
        value_next = value_reg;
        idx_next   = idx_reg;
        right_next = right_reg;
        res_next   = res_reg;
        st_next    = st_reg;

        // a waiting result leaves when the receiver takes it
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        ram_we    = 1'b0;
        ram_waddr = fill_reg[AW-1:0];
        ram_wdata = value_reg;
        ram_re    = 1'b0;
        ram_raddr = top_pos[AW-1:0];

        alu_req.start = 1'b0;
        alu_req.op    = op_reg;

        s_tready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = opcode_t'(s_tuser[OP_W-1:0]);
                    value_next = s_tdata[WORD_W-1:0];
                    idx_next   = s_tdata[WORD_W+IDX_W-1:WORD_W];
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_next   = '0;
                st_next    = ST_OK;
                state_next = S_DONE;
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (fill_reg == FULL_COUNT)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (fill_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            fill_next  = top_pos;
                            state_next = S_RD_WAIT;
                        end
                    end
                    OP_PEEK_TOP, OP_PEEK_BOTTOM:
                    begin
                        if (idx_ext >= fill_ext)
                        begin
                            st_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = (op_reg == OP_PEEK_TOP) ? peek_pos[AW-1:0]
                                                                 : idx_ext[AW-1:0];
                            state_next = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        // arithmetic needs two operands
                        if (fill_reg < CW'(2))
                        begin
                            st_next = ST_FEW_OPERANDS;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_RD_LEFT;
                        end
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                res_next   = ram_rdata;
                state_next = S_DONE;
            end
            S_RD_LEFT:
            begin
                right_next = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = second_pos[AW-1:0];
                state_next = S_ALU_GO;
            end
            S_ALU_GO:
            begin
                alu_req.start = 1'b1;
                state_next    = S_ALU_WAIT;
            end
            S_ALU_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.div_zero)
                    begin
                        // both operands dropped, nothing pushed
                        st_next   = ST_DIV_ZERO;
                        res_next  = '0;
                        fill_next = second_pos;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = second_pos[AW-1:0];
                        ram_wdata = alu_result;
                        res_next  = alu_result;
                        fill_next = top_pos;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{M_PAD_W{1'b0}}, depth_wide[DEPTH_OUT_W-1:0], res_reg};
                    out_user_next  = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        idx_reg      <= idx_next;
        right_reg    <= right_next;
        res_reg      <= res_next;
        st_reg       <= st_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/rpn_chk.sv @@
`default_nettype none

`include "rpn_stack_calculator_top_assert.svh"

module rpn_chk
    import rpn_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    logic                           in_take;
    logic                           out_stall;
    logic [M_TUSER_W+M_TDATA_W-1:0] m_item;
    logic                           status_known;
    logic                           error_item;
    logic                           result_zero;
    logic                           pad_zero;

    assign in_take      = s_tvalid && s_tready;
    assign out_stall    = m_tvalid && !m_tready;
    assign m_item       = {m_tuser, m_tdata};
    assign status_known = m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_EMPTY
                       || m_tuser == ST_BAD_INDEX || m_tuser == ST_FEW_OPERANDS
                       || m_tuser == ST_DIV_ZERO;
    assign error_item   = m_tvalid && (m_tuser != ST_OK);
    assign result_zero  = (m_tdata[WORD_W-1:0] == '0);
    assign pad_zero     = (m_tdata[M_TDATA_W-1:WORD_W+DEPTH_OUT_W] == '0);

    // stalled result holds its payload
    `RPN_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_item), "stalled result changed")

    // one item in flight: no accept in the cycle after an accept
    `RPN_ASSERT_NEXT(a_one_in_flight, in_take, !s_tready, "item accepted while busy")

    // status is a defined code
    `RPN_ASSERT_IMPLY(a_status_code, m_tvalid, status_known, "undefined status code")

    // an error result carries zero
    `RPN_ASSERT_IMPLY(a_error_zero, error_item, result_zero, "error item with nonzero result")

    // the pad bits of the result stay zero
    `RPN_ASSERT_IMPLY(a_pad_zero, m_tvalid, pad_zero, "result pad bits set")

endmodule

bind rpn_stack_calculator_top rpn_chk u_rpn_chk (.*);

`default_nettype wire

@@ verif/rpn_stack_calculator_checker.sv @@
`default_nettype none

module rpn_stack_calculator_checker
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // value[31:0], index[41:32], zero pad
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // operation[2:0]
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,   // result[31:0], depth_now[42:32], zero pad
    input  wire logic [M_TUSER_W-1:0] m_tuser,   // status[2:0]
    output int                        fail_count,
    output int                        awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [WORD_W-1:0]      value;
        status_t                status;
        logic [DEPTH_OUT_W-1:0] depth;
    } calc_reply_t;

    logic [WORD_W-1:0] operand_stack [STACK_DEPTH];
    int unsigned       fill_level;
    calc_reply_t       replies_due [$];
    calc_reply_t       want;
    logic [WORD_W-1:0] got_value;
    logic [DEPTH_OUT_W-1:0] got_depth;
    logic [STATUS_W-1:0]    got_status;
    int                faults;

    // quotient rounded toward minus infinity, wrapped to the word
    function automatic logic [WORD_W-1:0] floor_quotient(logic [WORD_W-1:0] left,
                                                         logic [WORD_W-1:0] right);
        longint num;
        longint den;
        longint quo;
        longint rem;
        num = longint'($signed(left));
        den = longint'($signed(right));
        quo = num / den;
        rem = num % den;
        if (rem != 0 && ((rem < 0) != (den < 0)))
            quo = quo - 1;
        return quo[WORD_W-1:0];
    endfunction

    function automatic calc_reply_t apply_op(opcode_t op, logic [WORD_W-1:0] val,
                                             logic [IDX_W-1:0] idx);
        calc_reply_t       rep;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        rep.value  = '0;
        rep.status = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (fill_level >= STACK_DEPTH)
                    rep.status = ST_FULL;
                else
                begin
                    operand_stack[fill_level] = val;
                    fill_level++;
                end
            end
            OP_POP:
            begin
                if (fill_level == 0)
                    rep.status = ST_EMPTY;
                else
                begin
                    fill_level--;
                    rep.value = operand_stack[fill_level];
                end
            end
            OP_PEEK_TOP:
            begin
                if (idx >= fill_level)
                    rep.status = ST_BAD_INDEX;
                else
                    rep.value = operand_stack[fill_level - 1 - idx];
            end
            OP_PEEK_BOTTOM:
            begin
                if (idx >= fill_level)
                    rep.status = ST_BAD_INDEX;
                else
                    rep.value = operand_stack[idx];
            end
            default:
            begin
                if (fill_level < 2)
                    rep.status = ST_FEW_OPERANDS;
                else
                begin
                    right = operand_stack[fill_level - 1];
                    left  = operand_stack[fill_level - 2];
                    fill_level -= 2;
                    case (op)
                        OP_ADD:  rep.value = left + right;
                        OP_SUB:  rep.value = left - right;
                        OP_MUL:  rep.value = left * right;
                        default:
                        begin
                            if (right == '0)
                                rep.status = ST_DIV_ZERO;
                            else
                                rep.value = floor_quotient(left, right);
                        end
                    endcase
                    // divide by zero drops both operands and pushes nothing
                    if (rep.status != ST_DIV_ZERO)
                    begin
                        operand_stack[fill_level] = rep.value;
                        fill_level++;
                    end
                end
            end
        endcase
        rep.depth = DEPTH_OUT_W'(fill_level);
        return rep;
    endfunction

    task automatic note_fault(string what);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_level = 0;
            faults     = 0;
            replies_due.delete();
            fail_count <= 0;
            awaited    <= 0;
        end
        else
        begin
            // results first: an item taken at this edge cannot have its result here
            if (m_tvalid && m_tready)
            begin
                got_value  = m_tdata[WORD_W-1:0];
                got_depth  = m_tdata[WORD_W +: DEPTH_OUT_W];
                got_status = m_tuser;
                if (replies_due.size() == 0)
                    note_fault($sformatf("unexpected result item: result %h status %0d depth %0d",
                                         got_value, got_status, got_depth));
                else
                begin
                    want = replies_due.pop_front();
                    if (got_value !== want.value || got_status !== want.status
                        || got_depth !== want.depth)
                        note_fault($sformatf({"result mismatch: expected result %h status %0d ",
                                              "depth %0d, got result %h status %0d depth %0d"},
                                             want.value, want.status, want.depth,
                                             got_value, got_status, got_depth));
                end
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(apply_op(opcode_t'(s_tuser), s_tdata[WORD_W-1:0],
                                               s_tdata[WORD_W +: IDX_W]));
            fail_count <= faults;
            awaited    <= replies_due.size();
        end
    end

endmodule

`default_nettype wire

@@ verif/rpn_stack_calculator_top_tb.sv @@
`default_nettype none

module rpn_stack_calculator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int     STACK_DEPTH  = 1024;
    localparam int     CLK_HALF     = 6;
    localparam int     RESET_CYCLES = 5;
    localparam int     RANDOM_ITEMS = 770;
    localparam int     MAX_GAP      = 10;
    // covers the longest operation, a divide, plus a receiver stall
    localparam int     SETTLE_CYCLES = 80;
    localparam longint CYCLE_LIMIT  = 1_000_000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // value[31:0], index[41:32], zero pad
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // operation[2:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // result[31:0], depth_now[42:32], zero pad
    logic [M_TUSER_W-1:0] m_tuser;         // status[2:0]

    int     fail_count;
    int     awaited;
    // rough stack depth, only used to steer the op mix and the peek index;
    // a divide by zero drops one entry more than assumed, so this never underestimates
    int     depth_guess = 0;
    bit     tx_eager    = 1'b0;
    bit     rx_eager    = 1'b0;
    longint cycle_count = 0;

    always #(CLK_HALF) clk = ~clk;

    rpn_stack_calculator_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predicts every accepted item and checks every result item
    rpn_stack_calculator_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[rpn_stack_calculator_top] ERROR");
            $finish;
        end
    end

    // operand values: extremes, small numbers (zero and minus one for divides)
    // and full random words
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5, 6: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    // mostly a valid offset into the stack, sometimes any 10-bit index
    function automatic logic [IDX_W-1:0] pick_index();
        if (depth_guess > 0 && $urandom_range(0, 99) < 85)
            return IDX_W'($urandom_range(0, depth_guess - 1));
        return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    endfunction

    // offer one item after a random gap and hold it until it is taken;
    // tvalid stays high straight into the next item when the gap is zero
    task automatic send_op(opcode_t op, logic [WORD_W-1:0] val, logic [IDX_W-1:0] idx);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_eager = !tx_eager;
        gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{S_PAD_W{1'b0}}, idx, val};
        do
            @(posedge clk);
        while (!s_tready);
        case (op)
            OP_PUSH:                     if (depth_guess < STACK_DEPTH) depth_guess++;
            OP_POP:                      if (depth_guess > 0) depth_guess--;
            OP_PEEK_TOP, OP_PEEK_BOTTOM: ;
            default:                     if (depth_guess >= 2) depth_guess--;
        endcase
    endtask

    // one random item with the given push and pop shares in percent;
    // peeks take a fifth and the four arithmetic ops the rest
    task automatic random_step(int push_pct, int pop_pct);
        int      roll;
        opcode_t op;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            op = OP_PUSH;
        else if (roll < push_pct + pop_pct)
            op = OP_POP;
        else if (roll < push_pct + pop_pct + 20)
            op = $urandom_range(0, 1) ? OP_PEEK_TOP : OP_PEEK_BOTTOM;
        else
            op = opcode_t'($urandom_range(OP_ADD, OP_DIV));
        send_op(op, pick_value(), pick_index());
    endtask

    // result side: random stall before each item, with stretches of none
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_eager = !rx_eager;
            stall = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // errors on an empty stack
        send_op(OP_POP, 32'h0, 10'd0);
        send_op(OP_PEEK_TOP, 32'h0, 10'd0);
        send_op(OP_PEEK_BOTTOM, 32'hFFFF_FFFF, 10'd1023);
        send_op(OP_ADD, 32'h0, 10'd0);
        // too few operands with one entry, then add overflow
        send_op(OP_PUSH, 32'h7FFF_FFFF, 10'd0);
        send_op(OP_MUL, 32'h0, 10'd0);
        send_op(OP_PUSH, 32'h0000_0001, 10'd0);
        send_op(OP_ADD, 32'h0, 10'd0);
        // most negative over minus one wraps back to most negative
        send_op(OP_PUSH, 32'hFFFF_FFFF, 10'd0);
        send_op(OP_DIV, 32'h0, 10'd0);
        // subtract underflow
        send_op(OP_PUSH, 32'h0000_0001, 10'd0);
        send_op(OP_SUB, 32'h0, 10'd0);
        // divide by zero drops both operands
        send_op(OP_PUSH, 32'h0000_0000, 10'd0);
        send_op(OP_DIV, 32'h0, 10'd0);
        // floor division with mixed signs: -7/2 and 7/-2 both give -4
        send_op(OP_PUSH, 32'hFFFF_FFF9, 10'd0);
        send_op(OP_PUSH, 32'h0000_0002, 10'd0);
        send_op(OP_DIV, 32'h0, 10'd0);
        send_op(OP_PUSH, 32'h0000_0007, 10'd0);
        send_op(OP_PUSH, 32'hFFFF_FFFE, 10'd0);
        send_op(OP_DIV, 32'h0, 10'd0);
        // peeks from both ends, and an index just past the top
        send_op(OP_PEEK_TOP, 32'h0, 10'd0);
        send_op(OP_PEEK_BOTTOM, 32'h0, 10'd1);
        send_op(OP_PEEK_TOP, 32'h0, 10'd2);
        // multiply overflow
        send_op(OP_PUSH, 32'h7FFF_FFFF, 10'd0);
        send_op(OP_MUL, 32'h0, 10'd0);
        send_op(OP_POP, 32'h0, 10'd0);
        send_op(OP_POP, 32'h0, 10'd0);
        depth_guess = 0;

        // random mix at shallow depth, pushes favored when nearly empty
        repeat (RANDOM_ITEMS)
            random_step(depth_guess < 2 ? 70 : 35, 15);
        s_tvalid <= 1'b0;

        // wait for every expected result, then let the block settle
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("[rpn_stack_calculator_top] OK");
        else
            $display("[rpn_stack_calculator_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
